>>> hdl/touch_contact_slot_tracker_unit_defines.svh
// assertion macros shared by the slot tracker rtl
`ifndef TOUCH_CONTACT_SLOT_TRACKER_UNIT_DEFINES_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define TCST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tcst_pkg.sv
// constants, types and helpers for the touch contact slot tracker
`default_nettype none
package tcst_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int FINGER_W   = 32;
  localparam int RAW_X_W    = 11;
  localparam int RAW_Y_W    = 10;
  localparam int POS_W      = RAW_X_W + RAW_Y_W;
  localparam int EVENT_W    = 2;
  localparam int SCALED_W   = 19;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SURF_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SURF_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] SURF_WIDTH_RST  = 11'd1280;
  localparam logic [CFG_DATA_W-1:0] SURF_HEIGHT_RST = 11'd720;

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  localparam logic [EVENT_W-1:0] EV_DOWN = 2'd0;
  localparam logic [EVENT_W-1:0] EV_MOVE = 2'd1;
  localparam logic [EVENT_W-1:0] EV_UP   = 2'd2;

  localparam logic [SCALED_W-1:0] SCALED_MAX = '1;

  // x: raw*w*256/1280 = raw*w/5, reciprocal of 5 exact for products below 2^22
  localparam int PROD_X_W      = RAW_X_W + CFG_DATA_W;
  localparam int RECIP_X_W     = 22;
  localparam int RECIP_X_SHIFT = 24;
  localparam logic [RECIP_X_W-1:0] RECIP_X = 22'd3355444;
  localparam int QX_W          = PROD_X_W + RECIP_X_W;

  // y: raw*h*256/720 = raw*h*16/45, reciprocal of 45 exact for values below 2^28
  localparam int PROD_Y_W      = RAW_Y_W + CFG_DATA_W;
  localparam int Y_PRESHIFT    = 4;
  localparam int RECIP_Y_W     = 26;
  localparam int RECIP_Y_SHIFT = 31;
  localparam logic [RECIP_Y_W-1:0] RECIP_Y = 26'd47721859;
  localparam int QY_W          = PROD_Y_W + Y_PRESHIFT + RECIP_Y_W;

  typedef logic [SLOT_COUNT-1:0] slot_mask_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] idx;
  } first_t;

  // lowest set bit of a slot mask
  function automatic first_t find_first(input slot_mask_t v);
    first_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) begin
        r.found = 1'b1;
        r.idx   = SLOT_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/touch_contact_slot_tracker_unit.sv
// touch contact slot tracker: slot table, position memory and event sequencer
//
// Input channel (in_valid/in_ready) carries point reports (kind 0) and end of
// frame marks (kind 1). Output channel (out_valid/out_ready) carries down, move
// and up events; last flags the final event caused by one input item.
// Finger ids sit in a register bank compared in parallel; stored raw positions
// sit in a one-port synchronous memory read in the accept cycle and written
// back in the check state that follows, before the next item can be taken.
// A point passes through the check and emit states before the next item is
// taken; its event enters the output register in emit once that register is
// free. An unmoved point goes from check straight back to idle, and a point
// dropped on a full table never leaves idle. An end of frame that releases
// slots sends one up event per cycle from the output register while it is free.
// The scaling uses two registered multiplier stages (size product, reciprocal).
// A stalled receiver holds the output register and the sequencer waits on it;
// no event is lost. Reset empties the slot table, clears the seen marks and
// restores the screen size to 1280x720; positions are not cleared.
// Configuration writes take effect at the next clock edge.
`default_nettype none
`include "touch_contact_slot_tracker_unit_defines.svh"

module touch_contact_slot_tracker_unit
  import tcst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [FINGER_W-1:0]   contact_id,
  input  logic [RAW_X_W-1:0]    raw_x,
  input  logic [RAW_Y_W-1:0]    raw_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [EVENT_W-1:0]    event_res,
  output logic [SLOT_IDX_W-1:0] slot,
  output logic [SCALED_W-1:0]   x_scaled,
  output logic [SCALED_W-1:0]   y_scaled,
  output logic                  last
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_UP    = 2'd3;

  logic [1:0]            state;
  logic [CFG_DATA_W-1:0] surf_width;
  logic [CFG_DATA_W-1:0] surf_height;
  slot_mask_t            slot_active;
  slot_mask_t            seen_mask;
  slot_mask_t            up_pend;
  logic [FINGER_W-1:0]   slot_finger [SLOT_COUNT];

  logic [POS_W-1:0]      pos_mem [SLOT_COUNT];
  logic [POS_W-1:0]      pos_rdata;

  logic [SLOT_IDX_W-1:0] cur_slot;
  logic                  cur_hit;
  logic [FINGER_W-1:0]   cur_finger;
  logic [RAW_X_W-1:0]    cur_rx;
  logic [RAW_Y_W-1:0]    cur_ry;
  logic [PROD_X_W-1:0]   prod_x;
  logic [PROD_Y_W-1:0]   prod_y;
  logic [EVENT_W-1:0]    hold_event;
  logic [SCALED_W-1:0]   hold_x;
  logic [SCALED_W-1:0]   hold_y;

  logic                  in_fire;
  logic                  out_free;
  slot_mask_t            hit_vec;
  slot_mask_t            release_vec;
  first_t                hit_first;
  first_t                free_first;
  first_t                up_first;
  logic [SLOT_IDX_W-1:0] pick_slot;
  logic                  pick_ok;
  slot_mask_t            up_rem;
  logic                  moved;
  logic                  emit_point;
  logic [QX_W-1:0]       qx_wide;
  logic [QY_W-1:0]       qy_wide;
  logic [QX_W-RECIP_X_SHIFT-1:0] qx;
  logic [QY_W-RECIP_Y_SHIFT-1:0] qy;
  logic [SCALED_W-1:0]   x_sat;
  logic [SCALED_W-1:0]   y_sat;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // parallel finger compare over the slot bank
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = slot_active[i] && (slot_finger[i] == contact_id);
    end
  end

  assign release_vec = slot_active & ~seen_mask;
  assign hit_first   = find_first(hit_vec);
  assign free_first  = find_first(~slot_active);
  assign pick_slot   = hit_first.found ? hit_first.idx : free_first.idx;
  assign pick_ok     = hit_first.found || free_first.found;

  assign up_first = find_first(up_pend);
  always_comb begin
    up_rem = up_pend;
    up_rem[up_first.idx] = 1'b0;
  end

  assign moved      = ({cur_rx, cur_ry} != pos_rdata);
  assign emit_point = !cur_hit || moved;

  // second multiplier stage: divide by reciprocal
  assign qx_wide = QX_W'(prod_x) * QX_W'(RECIP_X);
  assign qy_wide = QY_W'({prod_y, {Y_PRESHIFT{1'b0}}}) * QY_W'(RECIP_Y);
  assign qx      = qx_wide[QX_W-1:RECIP_X_SHIFT];
  assign qy      = qy_wide[QY_W-1:RECIP_Y_SHIFT];
  assign x_sat   = (qx > (QX_W-RECIP_X_SHIFT)'(SCALED_MAX)) ? SCALED_MAX : qx[SCALED_W-1:0];
  assign y_sat   = (qy > (QY_W-RECIP_Y_SHIFT)'(SCALED_MAX)) ? SCALED_MAX : qy[SCALED_W-1:0];

  // position memory: read in the accept cycle, written back in check
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      pos_rdata <= pos_mem[pick_slot];
    end
    if (state == S_CHECK) begin
      pos_mem[cur_slot] <= {cur_rx, cur_ry};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      surf_width    <= SURF_WIDTH_RST;
      surf_height   <= SURF_HEIGHT_RST;
      slot_active   <= '0;
      seen_mask     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_SURF_WIDTH:  surf_width  <= cfg_wdata;
          CFG_SURF_HEIGHT: surf_height <= cfg_wdata;
          default: ;
        endcase
      end
      // output register loads in emit and up, drains on handshake otherwise
      if (((state == S_EMIT) || (state == S_UP)) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (kind == KIND_EOF) begin
              slot_active <= slot_active & seen_mask;
              seen_mask   <= '0;
              if (release_vec != '0) begin
                state <= S_UP;
              end
            end else if (pick_ok) begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          slot_active[cur_slot] <= 1'b1;
          seen_mask[cur_slot]   <= 1'b1;
          state <= emit_point ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_UP: begin
          if (out_free && (up_rem == '0)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          up_pend    <= release_vec;
          cur_slot   <= pick_slot;
          cur_hit    <= hit_first.found;
          cur_finger <= contact_id;
          cur_rx     <= raw_x;
          cur_ry     <= raw_y;
          prod_x     <= PROD_X_W'(raw_x) * PROD_X_W'(surf_width);
          prod_y     <= PROD_Y_W'(raw_y) * PROD_Y_W'(surf_height);
        end
      end
      S_CHECK: begin
        if (!cur_hit) begin
          slot_finger[cur_slot] <= cur_finger;
        end
        hold_event <= cur_hit ? EV_MOVE : EV_DOWN;
        hold_x     <= x_sat;
        hold_y     <= y_sat;
      end
      S_EMIT: begin
        if (out_free) begin
          event_res <= hold_event;
          slot      <= cur_slot;
          x_scaled  <= hold_x;
          y_scaled  <= hold_y;
          last      <= 1'b1;
        end
      end
      S_UP: begin
        if (out_free) begin
          event_res <= EV_UP;
          slot      <= up_first.idx;
          x_scaled  <= '0;
          y_scaled  <= '0;
          last      <= (up_rem == '0);
          up_pend   <= up_rem;
        end
      end
      default: ;
    endcase
  end

  `TCST_ASSERT_IMP(a_seen_in_active, clk, rst, 1'b1, (seen_mask & ~slot_active) == '0, "seen slot not active")
  `TCST_ASSERT_IMP(a_up_zero_pos, clk, rst, out_valid && (event_res == EV_UP), (x_scaled == '0) && (y_scaled == '0), "up event with position")
  `TCST_ASSERT_NEXT(a_eof_clears_seen, clk, rst, in_fire && (kind == KIND_EOF), seen_mask == '0, "seen marks kept after frame end")
  `TCST_ASSERT_NEXT(a_up_last_done, clk, rst, (state == S_UP) && out_free && (up_rem == '0), (state == S_IDLE) && out_valid && last, "final up event not marked last")

endmodule
`default_nettype wire

>>> sim/touch_contact_slot_tracker_unit_test.sv
// self-checking testbench for the touch contact slot tracker: random frames against a predictor
`default_nettype none

module touch_contact_slot_tracker_unit_test
  import tcst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 64;
  localparam int SETTLE_CYCLES = 12;
  localparam int POOL_SIZE    = 10;
  localparam int PHASE_COUNT  = 6;

  typedef struct packed {
    logic                kind;
    logic [FINGER_W-1:0] finger;
    logic [RAW_X_W-1:0]  px;
    logic [RAW_Y_W-1:0]  py;
  } contact_item_t;

  typedef struct packed {
    logic [EVENT_W-1:0]    ev;
    logic [SLOT_IDX_W-1:0] idx;
    logic [SCALED_W-1:0]   xs;
    logic [SCALED_W-1:0]   ys;
    logic                  is_last;
  } touch_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SURF_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  kind = KIND_POINT;
  logic [FINGER_W-1:0]   contact_id = '0;
  logic [RAW_X_W-1:0]    raw_x = '0;
  logic [RAW_Y_W-1:0]    raw_y = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [EVENT_W-1:0]    event_res;
  logic [SLOT_IDX_W-1:0] slot;
  logic [SCALED_W-1:0]   x_scaled;
  logic [SCALED_W-1:0]   y_scaled;
  logic                  last;

  touch_contact_slot_tracker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .contact_id (contact_id),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .slot      (slot),
    .x_scaled  (x_scaled),
    .y_scaled  (y_scaled),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // stimulus and expectations
  contact_item_t pending_items[$];
  touch_event_t  expected_events[$];
  int            queued_items = 0;

  // predictor state
  logic [CFG_DATA_W-1:0] screen_w = SURF_WIDTH_RST;
  logic [CFG_DATA_W-1:0] screen_h = SURF_HEIGHT_RST;
  logic                  slot_busy[SLOT_COUNT];
  logic [FINGER_W-1:0]   slot_owner[SLOT_COUNT];
  logic [RAW_X_W-1:0]    slot_px[SLOT_COUNT];
  logic [RAW_Y_W-1:0]    slot_py[SLOT_COUNT];
  slot_mask_t            frame_seen = '0;

  // run statistics
  int error_count = 0;
  int accepted_items = 0;
  int checked_events = 0;
  int down_count = 0, move_count = 0, up_count = 0;
  int dropped_points = 0, unchanged_points = 0, quiet_frames = 0;
  int settings_used = 1;

  // flow control knobs shared by the processes
  bit idle_en = 1'b0;
  int hold_left = 0;
  int stuck_cycles = 0;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) slot_busy[i] = 1'b0;
  end

  function automatic logic [SCALED_W-1:0] scale_pos(input logic [63:0] raw,
                                                    input logic [63:0] size,
                                                    input logic [63:0] span);
    logic [63:0] v;
    v = (raw * size * 64'd256) / span;
    return (v > 64'(SCALED_MAX)) ? SCALED_MAX : v[SCALED_W-1:0];
  endfunction

  function automatic void push_event(input logic [EVENT_W-1:0] ev, input int idx,
                                     input logic [SCALED_W-1:0] xs,
                                     input logic [SCALED_W-1:0] ys, input logic is_last);
    touch_event_t e;
    e.ev      = ev;
    e.idx     = SLOT_IDX_W'(idx);
    e.xs      = xs;
    e.ys      = ys;
    e.is_last = is_last;
    expected_events.push_back(e);
  endfunction

  // works out the events of one accepted item and updates the slot table
  function automatic void track_contact(input contact_item_t it);
    int hit;
    int last_up;
    logic [SCALED_W-1:0] xs, ys;
    hit = -1;
    last_up = -1;
    if (it.kind == KIND_EOF) begin
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_busy[i] && !frame_seen[i]) last_up = i;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_busy[i] && !frame_seen[i]) begin
          push_event(EV_UP, i, '0, '0, i == last_up);
          slot_busy[i] = 1'b0;
          up_count++;
        end
      end
      if (last_up < 0) quiet_frames++;
      frame_seen = '0;
    end else begin
      xs = scale_pos(64'(it.px), 64'(screen_w), 64'd1280);
      ys = scale_pos(64'(it.py), 64'(screen_h), 64'd720);
      for (int i = 0; i < SLOT_COUNT; i++)
        if (hit < 0 && slot_busy[i] && slot_owner[i] == it.finger) hit = i;
      if (hit < 0) begin
        for (int i = 0; i < SLOT_COUNT; i++)
          if (hit < 0 && !slot_busy[i]) hit = i;
        if (hit < 0) begin
          // table full
          dropped_points++;
          return;
        end
        slot_busy[hit]  = 1'b1;
        slot_owner[hit] = it.finger;
        push_event(EV_DOWN, hit, xs, ys, 1'b1);
        down_count++;
      end else if (it.px != slot_px[hit] || it.py != slot_py[hit]) begin
        push_event(EV_MOVE, hit, xs, ys, 1'b1);
        move_count++;
      end else begin
        unchanged_points++;
      end
      slot_px[hit] = it.px;
      slot_py[hit] = it.py;
      frame_seen[hit] = 1'b1;
    end
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // driver
  contact_item_t cur_item;
  int send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_contact(cur_item);
        accepted_items++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(1, 17) - 1;
          in_valid <= 1'b0;
        end else begin
          cur_item = pending_items.pop_front();
          kind       <= cur_item.kind;
          contact_id <= cur_item.finger;
          raw_x      <= cur_item.px;
          raw_y      <= cur_item.py;
          in_valid   <= 1'b1;
        end
      end
    end
  end

  // monitor
  int stall_left = 0;

  always @(posedge clk) begin
    touch_event_t got, want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.ev      = event_res;
        got.idx     = slot;
        got.xs      = x_scaled;
        got.ys      = y_scaled;
        got.is_last = last;
        checked_events++;
        if (expected_events.size() == 0) begin
          flag_error($sformatf("unexpected event ev=%0d slot=%0d x=%0d y=%0d last=%0d",
                               got.ev, got.idx, got.xs, got.ys, got.is_last));
        end else begin
          want = expected_events.pop_front();
          if (got.ev !== want.ev || got.idx !== want.idx || got.xs !== want.xs ||
              got.ys !== want.ys || got.is_last !== want.is_last)
            flag_error($sformatf({"expected ev=%0d slot=%0d x=%0d y=%0d last=%0d, ",
                                  "got ev=%0d slot=%0d x=%0d y=%0d last=%0d"},
                                 want.ev, want.idx, want.xs, want.ys, want.is_last,
                                 got.ev, got.idx, got.xs, got.ys, got.is_last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout after %0d cycles without a handshake", STUCK_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // stimulus
  logic [FINGER_W-1:0] pool_id[POOL_SIZE];
  logic [RAW_X_W-1:0]  pool_x[POOL_SIZE];
  logic [RAW_Y_W-1:0]  pool_y[POOL_SIZE];

  function automatic void queue_item(input logic k, input logic [FINGER_W-1:0] f,
                                     input logic [RAW_X_W-1:0] x,
                                     input logic [RAW_Y_W-1:0] y);
    contact_item_t it;
    it.kind   = k;
    it.finger = f;
    it.px     = x;
    it.py     = y;
    pending_items.push_back(it);
    queued_items++;
  endfunction

  function automatic void refresh_finger(input int j);
    pool_id[j] = $urandom;
    pool_x[j]  = RAW_X_W'($urandom_range(0, 1279));
    pool_y[j]  = RAW_Y_W'($urandom_range(0, 719));
  endfunction

  // mostly small moves or no move, sometimes a jump, rarely off the panel range
  function automatic void nudge_finger(input int j);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ;
      4, 5, 6, 7: begin
        pool_x[j] = pool_x[j] + RAW_X_W'($urandom_range(0, 8)) - RAW_X_W'(4);
        pool_y[j] = pool_y[j] + RAW_Y_W'($urandom_range(0, 8)) - RAW_Y_W'(4);
      end
      8: begin
        pool_x[j] = RAW_X_W'($urandom_range(0, 1279));
        pool_y[j] = RAW_Y_W'($urandom_range(0, 719));
      end
      default: begin
        pool_x[j] = RAW_X_W'($urandom);
        pool_y[j] = RAW_Y_W'($urandom);
      end
    endcase
  endfunction

  function automatic void queue_frame(input int noise_pct);
    int start;
    int j;
    start = $urandom_range(0, POOL_SIZE - 1);
    for (int k = 0; k < POOL_SIZE; k++) begin
      j = (start + k) % POOL_SIZE;
      if ($urandom_range(0, 99) < 65) begin
        nudge_finger(j);
        queue_item(KIND_POINT, pool_id[j], pool_x[j], pool_y[j]);
        if ($urandom_range(0, 9) == 0) begin
          nudge_finger(j);
          queue_item(KIND_POINT, pool_id[j], pool_x[j], pool_y[j]);
        end
      end
      if ($urandom_range(0, 99) < noise_pct)
        queue_item(1'($urandom), $urandom, RAW_X_W'($urandom), RAW_Y_W'($urandom));
    end
    if ($urandom_range(0, 3) == 0) refresh_finger($urandom_range(0, POOL_SIZE - 1));
    queue_item(KIND_EOF, $urandom, RAW_X_W'($urandom), RAW_Y_W'($urandom));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_SURF_WIDTH) screen_w = val;
    else screen_h = val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // everything sent and answered, then a settling wait for items without events
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] width_set[PHASE_COUNT];
    logic [CFG_DATA_W-1:0] height_set[PHASE_COUNT];
    int phase_end;
    width_set  = '{11'd1920, 11'd1, 11'd0, 11'd2047, 11'd0, SURF_WIDTH_RST};
    height_set = '{11'd1080, 11'd1, 11'd0, 11'd2047, 11'd0, SURF_HEIGHT_RST};
    width_set[4]  = CFG_DATA_W'($urandom_range(2, 1919));
    height_set[4] = CFG_DATA_W'($urandom_range(2, 1079));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, unchanged position, same finger twice, quiet frame
    queue_item(KIND_POINT, 32'h0000_0000, 11'd0, 10'd0);
    queue_item(KIND_POINT, 32'hFFFF_FFFF, 11'd1279, 10'd719);
    queue_item(KIND_POINT, 32'h0000_0000, 11'd0, 10'd0);
    queue_item(KIND_POINT, 32'h0000_0000, 11'd2047, 10'd1023);
    queue_item(KIND_POINT, 32'hFFFF_FFFF, 11'd5, 10'd6);
    queue_item(KIND_POINT, 32'hFFFF_FFFF, 11'd5, 10'd6);
    queue_item(KIND_EOF, 32'hFFFF_FFFF, 11'd2047, 10'd1023);
    queue_item(KIND_EOF, 32'h0000_0000, 11'd0, 10'd0);
    // fill the table, then overflow it
    for (int i = 0; i < SLOT_COUNT; i++)
      queue_item(KIND_POINT, 32'h5A5A_0000 + i, RAW_X_W'(160 * i), RAW_Y_W'(90 * i));
    queue_item(KIND_POINT, 32'hA5A5_A5A5, 11'd640, 10'd360);
    queue_item(KIND_EOF, '0, '0, '0);
    queue_item(KIND_POINT, 32'h5A5A_0003, 11'd1, 10'd1);
    queue_item(KIND_EOF, '0, '0, '0);
    queue_item(KIND_EOF, '0, '0, '0);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      idle_en = (p != PHASE_COUNT - 1);
      write_reg(CFG_SURF_WIDTH, width_set[p]);
      write_reg(CFG_SURF_HEIGHT, height_set[p]);
      settings_used++;
      // long receiver hold-off so the output backs up into the input
      if (p == 1) hold_left = 300;
      for (int j = 0; j < POOL_SIZE; j++) refresh_finger(j);
      phase_end = queued_items + PHASE_ITEMS;
      while (queued_items < phase_end) queue_frame(8);
      wait_drained();
    end

    if (expected_events.size() != 0)
      flag_error($sformatf("%0d expected events never arrived", expected_events.size()));
    $display("covered %0d items over %0d screen sizes: %0d down, %0d move, %0d up events",
             accepted_items, settings_used, down_count, move_count, up_count);
    $display("%0d points dropped on a full table, %0d unmoved points, %0d quiet frames",
             dropped_points, unchanged_points, quiet_frames);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches in %0d checked events", error_count, checked_events);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
